// File: rtl/timestamp_sorted_record_table_defines.svh
// assertion macros for the record table
`ifndef TIMESTAMP_SORTED_RECORD_TABLE_DEFINES_SVH
`define TIMESTAMP_SORTED_RECORD_TABLE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define TSRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define TSRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tsrt_pkg.sv
package tsrt_pkg;

	localparam int DEF_TABLE_ENTRIES = 32;
	localparam int RESULT_LIMIT      = 32;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_QUERY  = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef struct packed {
		logic [15:0] year;
		logic [7:0]  month;
		logic [7:0]  day;
		logic [7:0]  hour;
		logic [7:0]  minute;
		logic [15:0] temp;
	} rec_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] key_year;
		logic [7:0]  key_month;
		logic [7:0]  key_day;
		logic [7:0]  key_hour;
		logic [7:0]  key_minute;
		logic [15:0] temp_tenths;
	} in_beat_t;

	typedef struct packed {
		logic        found;
		logic [15:0] rec_year;
		logic [7:0]  rec_month;
		logic [7:0]  rec_day;
		logic [7:0]  rec_hour;
		logic [7:0]  rec_minute;
		logic [15:0] rec_temp;
		logic        last;
	} out_beat_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_EVAL,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_PUT,
		ST_EMIT,
		ST_NONE,
		ST_WAIT
	} state_t;

	function automatic logic rec_empty(rec_t r);
		return r.year == 16'hffff || r.year == 16'h0000 || r.month == 8'hff ||
			r.month == 8'h00 || r.day == 8'hff || r.day == 8'h00 ||
			r.hour == 8'hff || r.minute == 8'hff;
	endfunction

endpackage

// File: rtl/tsrt_stream_if.sv
interface tsrt_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/timestamp_sorted_record_table.sv
// channel | dir | payload
// in      | in  | in_beat_t: opcode, key fields, temp_tenths
// out     | out | out_beat_t: found, record fields, last
// one item at a time; the table sits in one memory, one read or write a cycle
// insert: scan the entries in order (read, evaluate), then shift entries one at a time (read, write), then write
// query and lookup: each entry walked is read, then evaluated; a match adds an emit step, the final beat none and wait
// clear and after reset: a clearing pass writes every entry, input held off
// a stalled output beat holds the walk at the next match until it is taken
`include "timestamp_sorted_record_table_defines.svh"

module timestamp_sorted_record_table
	import tsrt_pkg::*;
#(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
	input  logic   clk,
	input  logic   arst_n,
	tsrt_stream_if.sink   in,
	tsrt_stream_if.source out
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(RESULT_LIMIT + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

	rec_t mem [TABLE_ENTRIES];

	state_t    state_q, state_d;
	logic [AW-1:0] idx_q;      // scan / walk index
	logic [AW-1:0] dst_q;      // shift destination
	logic [AW-1:0] pos_q;      // slot that takes the new record
	logic          up_q;       // shift direction: toward the end is 0
	logic [CW-1:0] cnt_q;
	in_beat_t  req_q;
	rec_t      rd_s1;
	rec_t      prev_q;          // entry i held while i+1 is read
	logic      have_prev_q;
	rec_t      shift_q;
	rec_t      stg_q;           // latest match, sent once the next step is known
	out_beat_t obeat_q;
	logic      ovalid_q;

	logic        we;
	logic [AW-1:0] waddr;
	rec_t        wdata;
	logic        re;
	logic [AW-1:0] raddr;

	rec_t new_rec;
	assign new_rec = '{req_q.key_year, req_q.key_month, req_q.key_day,
		req_q.key_hour, req_q.key_minute, req_q.temp_tenths};
	logic [47:0] nkey, ekey, pkey;
	logic [31:0] nday, eday;
	assign nkey = new_rec[63:16];
	assign ekey = rd_s1[63:16];
	assign pkey = prev_q[63:16];
	assign nday = new_rec[63:32];
	assign eday = rd_s1[63:32];

	logic r_empty, idx_last, out_free;
	assign r_empty  = rec_empty(rd_s1);
	assign idx_last = idx_q == LAST_IDX;
	assign out_free = !ovalid_q || out.ready;

	// slot for a mid-table insert
	logic [AW-1:0] pos_sel;
	assign pos_sel = have_prev_q ? idx_q : '0;

	// next shift destination
	logic [AW-1:0] dst_nx;
	assign dst_nx = up_q ? dst_q + AW'(1) : dst_q - AW'(1);

	// query emit is last when the limit is hit or the walk ends
	logic emit_last;
	assign emit_last = (cnt_q == CW'(RESULT_LIMIT - 1)) || idx_last;

	// a match is staged at once; an earlier staged match needs the output free
	logic emit_go, beat_load;
	assign emit_go   = out_free || cnt_q == '0;
	assign beat_load = (state_q == ST_EMIT && emit_go && cnt_q != '0) ||
		(state_q == ST_NONE && out_free);

	// table memory
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rd_s1 <= mem[raddr];
	end

	// eval decisions
	typedef enum logic [2:0] {
		EV_NEXT, EV_PUT, EV_SHIFT_DN, EV_SHIFT_UP, EV_EMIT, EV_DONE, EV_MISS
	} ev_t;
	ev_t ev;
	always_comb begin
		ev = EV_NEXT;
		case (op_t'(req_q.opcode))
			OP_INSERT: begin
				// entry idx is in rd_s1, prev is entry idx-1
				if (have_prev_q && nkey > pkey && nkey < ekey)
					ev = EV_SHIFT_DN;
				else if (r_empty || ekey == nkey)
					ev = EV_PUT;
				else if (!have_prev_q && nkey < ekey)
					ev = EV_SHIFT_DN;
				else if (idx_last)
					ev = EV_SHIFT_UP;
			end
			OP_QUERY: begin
				if (r_empty || eday > nday)
					ev = EV_DONE;
				else if (eday == nday)
					ev = EV_EMIT;
				else if (idx_last)
					ev = EV_DONE;
			end
			OP_LOOKUP: begin
				if (r_empty)
					ev = EV_MISS;
				else if (ekey == nkey)
					ev = EV_EMIT;
				else if (idx_last)
					ev = EV_MISS;
			end
			default: ev = EV_DONE;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:    if (idx_last) state_d = ST_IDLE;
			ST_IDLE:     if (in.valid) state_d = (op_t'(in.payload.opcode) == OP_CLEAR) ?
				ST_CLEAR : ST_RD;
			ST_RD:       state_d = ST_EVAL;
			ST_EVAL: begin
				case (ev)
					EV_NEXT:     state_d = ST_RD;
					EV_PUT:      state_d = ST_PUT;
					EV_SHIFT_DN: state_d = (pos_sel == LAST_IDX) ? ST_PUT : ST_SHIFT_RD;
					EV_SHIFT_UP: state_d = ST_SHIFT_RD;
					EV_EMIT:     state_d = ST_EMIT;
					EV_DONE:     state_d = ST_NONE;
					EV_MISS:     state_d = ST_NONE;
					default:     state_d = ST_IDLE;
				endcase
			end
			ST_SHIFT_RD: state_d = ST_SHIFT_WR;
			ST_SHIFT_WR: state_d = (dst_nx == pos_q) ? ST_PUT : ST_SHIFT_RD;
			ST_PUT:      state_d = ST_IDLE;
			ST_EMIT: begin
				if (emit_go) begin
					if (op_t'(req_q.opcode) == OP_LOOKUP || emit_last)
						state_d = ST_NONE;
					else
						state_d = ST_RD;
				end
			end
			ST_NONE:     if (out_free) state_d = ST_WAIT;
			ST_WAIT:     if (!ovalid_q || out.ready) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = new_rec;
		re    = 1'b0;
		raddr = idx_q;
		case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				wdata = '1;
			end
			ST_RD:   re = 1'b1;
			ST_SHIFT_RD: begin
				re    = 1'b1;
				raddr = dst_nx;
			end
			ST_SHIFT_WR: begin
				we    = 1'b1;
				waddr = dst_q;
				wdata = rd_s1;
			end
			ST_PUT: begin
				we    = 1'b1;
				waddr = pos_q;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			idx_q       <= '0;
			dst_q       <= '0;
			pos_q       <= '0;
			up_q        <= 1'b0;
			cnt_q       <= '0;
			have_prev_q <= 1'b0;
			ovalid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (beat_load)
				ovalid_q <= 1'b1;
			else if (out.ready)
				ovalid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: idx_q <= idx_last ? '0 : idx_q + AW'(1);
				ST_IDLE: begin
					idx_q       <= '0;
					cnt_q       <= '0;
					have_prev_q <= 1'b0;
				end
				ST_EVAL: begin
					case (ev)
						EV_NEXT: begin
							idx_q       <= idx_q + AW'(1);
							have_prev_q <= 1'b1;
						end
						EV_PUT: pos_q <= idx_q;
						EV_SHIFT_DN: begin
							pos_q <= pos_sel;
							dst_q <= LAST_IDX;
							up_q  <= 1'b0;
						end
						EV_SHIFT_UP: begin
							pos_q <= LAST_IDX;
							dst_q <= '0;
							up_q  <= 1'b1;
						end
						default: ;
					endcase
				end
				ST_SHIFT_WR: dst_q <= dst_nx;
				ST_EMIT: begin
					if (emit_go) begin
						cnt_q       <= cnt_q + CW'(1);
						idx_q       <= idx_q + AW'(1);
						have_prev_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in.valid)
			req_q <= in.payload;
		if (state_q == ST_EVAL)
			prev_q <= rd_s1;
		if (state_q == ST_EMIT && emit_go)
			stg_q <= rd_s1;
		// an earlier match goes out once another one follows
		if (state_q == ST_EMIT && emit_go && cnt_q != '0)
			obeat_q <= '{1'b1, stg_q.year, stg_q.month, stg_q.day, stg_q.hour,
				stg_q.minute, stg_q.temp, 1'b0};
		// final beat: the staged match, or no match at all
		if (state_q == ST_NONE && out_free) begin
			if (cnt_q == '0)
				obeat_q <= '{1'b0, 16'h0, 8'h0, 8'h0, 8'h0, 8'h0, 16'h0, 1'b1};
			else
				obeat_q <= '{1'b1, stg_q.year, stg_q.month, stg_q.day, stg_q.hour,
					stg_q.minute, stg_q.temp, 1'b1};
		end
	end

	// handshake outputs
	assign in.ready    = state_q == ST_IDLE;
	assign out.valid   = ovalid_q;
	assign out.payload = obeat_q;

	`TSRT_ASSERT_IMP(a_ready_idle, clk, arst_n, in.ready, !ovalid_q || state_q == ST_IDLE,
		"ready outside idle")
	`TSRT_ASSERT_IMP(a_cnt_limit, clk, arst_n, 1'b1, cnt_q <= CW'(RESULT_LIMIT),
		"result count over limit")
	`TSRT_ASSERT_NEXT(a_stall_hold, clk, arst_n, out.valid && !out.ready,
		out.valid, "beat dropped while stalled")
	`TSRT_ASSERT_NEXT(a_stall_stable, clk, arst_n, out.valid && !out.ready,
		$stable(out.payload), "beat changed while stalled")
	`TSRT_ASSERT_IMP(a_no_write_busy, clk, arst_n, state_q == ST_EMIT, !we,
		"write during emit")

endmodule

// File: tb/sv/timestamp_sorted_record_table_tb.sv
`timescale 1ns / 1ps

module timestamp_sorted_record_table_tb;
	import tsrt_pkg::*;

	localparam int ENTRIES    = DEF_TABLE_ENTRIES;
	localparam int MAX_BEATS  = RESULT_LIMIT;
	localparam int DRAIN_WAIT = 400;

	typedef struct packed {
		in_beat_t  beat;
		logic      typed;
		out_beat_t exp;
	} stim_row_t;

	localparam out_beat_t NO_MATCH = out_beat_t'(66'd1);

	logic clk;
	logic arst_n;

	tsrt_stream_if #(.payload_t(in_beat_t))  in_if ();
	tsrt_stream_if #(.payload_t(out_beat_t)) out_if ();

	timestamp_sorted_record_table i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in_if.sink),
		.out    (out_if.source)
	);

	// shadow copy of the table and the beats still owed by the block
	logic [63:0] shadow_table [ENTRIES];
	out_beat_t   pending_beats [$];

	int mismatches = 0;
	int beats_checked = 0;
	int n_insert, n_query, n_lookup, n_clear;
	int widest_answer;
	int burst_left;
	bit hold_req;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow model helpers
	function automatic bit slot_vacant(logic [63:0] r);
		return r[63:48] == 16'hffff || r[63:48] == 16'h0000 ||
			r[47:40] == 8'hff || r[47:40] == 8'h00 ||
			r[39:32] == 8'hff || r[39:32] == 8'h00 ||
			r[31:24] == 8'hff || r[23:16] == 8'hff;
	endfunction

	function automatic out_beat_t hit_beat(logic [63:0] r);
		out_beat_t b;
		b = '0;
		b.found      = 1'b1;
		b.rec_year   = r[63:48];
		b.rec_month  = r[47:40];
		b.rec_day    = r[39:32];
		b.rec_hour   = r[31:24];
		b.rec_minute = r[23:16];
		b.rec_temp   = r[15:0];
		return b;
	endfunction

	// sorted placement into the shadow table
	task automatic place_record(logic [63:0] nr);
		logic [47:0] nk;
		int i;
		int j;
		bit stop;
		nk = nr[63:16];
		stop = 0;
		if (slot_vacant(shadow_table[0]) || shadow_table[0][63:16] == nk) begin
			shadow_table[0] = nr;
			return;
		end
		if (nk < shadow_table[0][63:16]) begin
			for (j = ENTRIES - 1; j > 0; j--) shadow_table[j] = shadow_table[j-1];
			shadow_table[0] = nr;
			return;
		end
		for (i = 0; i < ENTRIES && !stop; i++) begin
			if (slot_vacant(shadow_table[i]) || shadow_table[i][63:16] == nk) begin
				shadow_table[i] = nr;
				return;
			end
			if (i < ENTRIES - 1 && nk > shadow_table[i][63:16] &&
					nk < shadow_table[i+1][63:16])
				stop = 1;
		end
		if (stop) i--;
		if (i < ENTRIES - 1) begin
			for (j = ENTRIES - 1; j >= i + 2; j--) shadow_table[j] = shadow_table[j-1];
			shadow_table[i+1] = nr;
		end else begin
			for (j = 0; j < ENTRIES - 1; j++) shadow_table[j] = shadow_table[j+1];
			shadow_table[ENTRIES-1] = nr;
		end
	endtask

	// apply one accepted beat to the shadow and queue the owed answers
	task automatic predict_beat(in_beat_t b, bit typed, out_beat_t typed_exp);
		logic [63:0] nr;
		out_beat_t   answer [$];
		int i;
		nr = {b.key_year, b.key_month, b.key_day, b.key_hour, b.key_minute,
			b.temp_tenths};
		case (op_t'(b.opcode))
			OP_INSERT: begin
				n_insert++;
				place_record(nr);
			end
			OP_CLEAR: begin
				n_clear++;
				foreach (shadow_table[k]) shadow_table[k] = '1;
			end
			OP_QUERY: begin
				n_query++;
				for (i = 0; i < ENTRIES && answer.size() < MAX_BEATS; i++) begin
					if (slot_vacant(shadow_table[i])) break;
					if (shadow_table[i][63:32] > nr[63:32]) break;
					if (shadow_table[i][63:32] == nr[63:32])
						answer.push_back(hit_beat(shadow_table[i]));
				end
			end
			default: begin
				n_lookup++;
				for (i = 0; i < ENTRIES; i++) begin
					if (slot_vacant(shadow_table[i])) break;
					if (shadow_table[i][63:16] == nr[63:16]) begin
						answer.push_back(hit_beat(shadow_table[i]));
						break;
					end
				end
			end
		endcase
		if (op_t'(b.opcode) == OP_QUERY || op_t'(b.opcode) == OP_LOOKUP) begin
			if (answer.size() == 0) answer.push_back('0);
			answer[answer.size()-1].last = 1'b1;
			if (answer.size() > widest_answer) widest_answer = answer.size();
			if (typed) pending_beats.push_back(typed_exp);
			else foreach (answer[k]) pending_beats.push_back(answer[k]);
		end
	endtask

	// send one beat, with bursts and gaps on the input side
	task automatic send_beat(in_beat_t b, bit typed, out_beat_t typed_exp);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				in_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_if.valid   <= 1'b1;
		in_if.payload <= b;
		do @(posedge clk); while (!in_if.ready);
		predict_beat(b, typed, typed_exp);
	endtask

	function automatic in_beat_t make_beat(op_t op, logic [15:0] y, logic [7:0] mo,
			logic [7:0] d, logic [7:0] h, logic [7:0] mi, logic [15:0] t);
		in_beat_t b;
		b.opcode      = op;
		b.key_year    = y;
		b.key_month   = mo;
		b.key_day     = d;
		b.key_hour    = h;
		b.key_minute  = mi;
		b.temp_tenths = t;
		return b;
	endfunction

	// mostly keys from a narrow calendar, sometimes any bit pattern
	function automatic in_beat_t random_beat();
		in_beat_t b;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) b.opcode = OP_INSERT;
		else if (pick < 78) b.opcode = OP_QUERY;
		else if (pick < 96) b.opcode = OP_LOOKUP;
		else b.opcode = OP_CLEAR;
		if ($urandom_range(0, 99) < 15) begin
			b.key_year   = 16'($urandom);
			b.key_month  = 8'($urandom);
			b.key_day    = 8'($urandom);
			b.key_hour   = 8'($urandom);
			b.key_minute = 8'($urandom);
		end else begin
			b.key_year   = 16'd2023 + 16'($urandom_range(0, 1));
			b.key_month  = 8'($urandom_range(1, 2));
			b.key_day    = 8'($urandom_range(1, 3));
			b.key_hour   = 8'($urandom_range(0, 5));
			b.key_minute = 8'($urandom_range(0, 3) * 15);
		end
		b.temp_tenths = 16'($urandom);
		return b;
	endfunction

	// receiver: stall pattern of its own, plus one long hold-off on request
	initial begin
		int mode;
		int left;
		bit held;
		out_if.ready <= 1'b0;
		left = 0;
		mode = 0;
		held = 0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1;
				out_if.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(16, 80);
			end
			left--;
			case (mode)
				0:       out_if.ready <= 1'b1;
				1:       out_if.ready <= 1'($urandom_range(0, 1));
				default: out_if.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin
		out_beat_t want;
		out_beat_t got;
		if (arst_n && out_if.valid && out_if.ready) begin
			got = out_if.payload;
			beats_checked++;
			if (pending_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %h at %0t", got, $realtime);
			end else begin
				want = pending_beats.pop_front();
				if (got.found !== want.found || got.rec_year !== want.rec_year ||
						got.rec_month !== want.rec_month || got.rec_day !== want.rec_day ||
						got.rec_hour !== want.rec_hour ||
						got.rec_minute !== want.rec_minute ||
						got.rec_temp !== want.rec_temp || got.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at %0t: exp f=%b %h/%h/%h %h:%h t=%h l=%b",
							$realtime, want.found, want.rec_year, want.rec_month,
							want.rec_day, want.rec_hour, want.rec_minute, want.rec_temp,
							want.last);
						$display("                  got f=%b %h/%h/%h %h:%h t=%h l=%b",
							got.found, got.rec_year, got.rec_month, got.rec_day,
							got.rec_hour, got.rec_minute, got.rec_temp, got.last);
					end
				end
			end
		end
	end

	// watchdog
	initial begin
		#3_000_000;
		$display("timeout with %0d result beats outstanding", pending_beats.size());
		$display("TB_ERROR");
		$finish;
	end

	// stimulus
	initial begin
		stim_row_t dir_rows [$];
		stim_row_t row;
		in_beat_t  b;
		int order [$];
		int sent;
		int waited;
		int k;

		clk = 1'b0;
		arst_n = 1'b0;
		in_if.valid <= 1'b0;
		in_if.payload <= '0;
		foreach (shadow_table[i]) shadow_table[i] = '1;
		n_insert = 0;
		n_query = 0;
		n_lookup = 0;
		n_clear = 0;
		widest_answer = 0;
		burst_left = 0;
		hold_req = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, ordering cases, empty keys, clear
		dir_rows = '{
			'{make_beat(OP_QUERY, 2024, 6, 15, 0, 0, 0), 1'b1, NO_MATCH},
			'{make_beat(OP_LOOKUP, 2024, 6, 15, 10, 20, 0), 1'b1, NO_MATCH},
			'{make_beat(OP_INSERT, 16'h0000, 1, 1, 0, 0, 16'h0000), 1'b0, '0},
			'{make_beat(OP_INSERT, 2024, 6, 15, 12, 30, 16'hffff), 1'b0, '0},
			'{make_beat(OP_INSERT, 2024, 6, 15, 8, 5, 250), 1'b0, '0},
			'{make_beat(OP_INSERT, 2024, 6, 16, 0, 0, 1), 1'b0, '0},
			'{make_beat(OP_INSERT, 2024, 6, 15, 20, 59, 300), 1'b0, '0},
			'{make_beat(OP_INSERT, 2024, 6, 15, 12, 30, 123), 1'b0, '0},
			'{make_beat(OP_INSERT, 16'hffff, 8'hff, 8'hff, 8'hff, 8'hff, 16'hffff),
				1'b0, '0},
			'{make_beat(OP_INSERT, 2024, 6, 14, 23, 0, 77), 1'b0, '0},
			'{make_beat(OP_QUERY, 2024, 6, 15, 8'hff, 8'hff, 16'hffff), 1'b0, '0},
			'{make_beat(OP_QUERY, 2024, 6, 14, 0, 0, 0), 1'b0, '0},
			'{make_beat(OP_QUERY, 2025, 1, 1, 0, 0, 0), 1'b0, '0},
			'{make_beat(OP_LOOKUP, 2024, 6, 15, 20, 59, 0), 1'b0, '0},
			'{make_beat(OP_LOOKUP, 2024, 6, 15, 20, 58, 0), 1'b0, '0},
			'{make_beat(OP_INSERT, 2024, 8'h00, 15, 0, 0, 5), 1'b0, '0},
			'{make_beat(OP_INSERT, 2024, 6, 15, 8'hff, 0, 6), 1'b0, '0},
			'{make_beat(OP_INSERT, 2024, 6, 15, 10, 8'hff, 7), 1'b0, '0},
			'{make_beat(OP_QUERY, 2024, 6, 16, 0, 0, 0), 1'b0, '0},
			'{make_beat(OP_CLEAR, 16'hffff, 8'hff, 8'hff, 8'hff, 8'hff, 16'hffff),
				1'b0, '0},
			'{make_beat(OP_QUERY, 2024, 6, 15, 0, 0, 0), 1'b1, NO_MATCH},
			'{make_beat(OP_LOOKUP, 2024, 6, 16, 0, 0, 0), 1'b1, NO_MATCH}
		};
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			send_beat(row.beat, row.typed, row.exp);
		end

		// fill one day past capacity in shuffled order, then ask for it while the
		// receiver holds off and the sender keeps offering
		sent = dir_rows.size();
		for (k = 0; k < ENTRIES + 2; k++) order.push_back(k);
		order.shuffle();
		foreach (order[i]) begin
			send_beat(make_beat(OP_INSERT, 2024, 6, 15, 8'(order[i]),
				8'($urandom_range(0, 59)), 16'($urandom)), 1'b0, '0);
			sent++;
		end
		hold_req = 1;
		send_beat(make_beat(OP_QUERY, 2024, 6, 15, 0, 0, 0), 1'b0, '0);
		send_beat(make_beat(OP_LOOKUP, 2024, 6, 15, 3, 0, 0), 1'b0, '0);
		send_beat(make_beat(OP_INSERT, 2024, 6, 15, 40, 0, 9), 1'b0, '0);
		send_beat(make_beat(OP_QUERY, 2024, 6, 15, 0, 0, 0), 1'b0, '0);
		sent += 4;

		// random traffic
		while (sent < 110) begin
			b = random_beat();
			send_beat(b, 1'b0, '0);
			sent++;
		end
		in_if.valid <= 1'b0;

		// drain, then allow for a trailing insert or clear
		waited = 0;
		while (pending_beats.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("ran %0d inserts, %0d day queries, %0d lookups, %0d clears",
			n_insert, n_query, n_lookup, n_clear);
		$display("checked %0d result beats, longest answer %0d beats",
			beats_checked, widest_answer);
		if (mismatches == 0 && pending_beats.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches, %0d beats missing", mismatches, pending_beats.size());
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/tsrt_pkg.sv
rtl/tsrt_stream_if.sv
rtl/timestamp_sorted_record_table.sv
tb/sv/timestamp_sorted_record_table_tb.sv
